FILE: rtl/smp_pkg.sv
// shared types and constants for the stride multiblock prefetcher
// no dependencies; imported by every rtl module of the block
package smp_pkg;

  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned DEPTH_W         = 3;
  localparam int unsigned TRUST_W         = 4;
  localparam int unsigned HISTORY_DEPTH   = 4;
  localparam int unsigned DEPTH_LIMIT     = 6;
  localparam int unsigned MAX_DEPTH_RESET = 6;

  localparam logic [TRUST_W-1:0] TRUST_MAX       = 4'd10;
  localparam logic [TRUST_W-1:0] TRUST_STEP_DOWN = 4'd2;
  localparam logic [TRUST_W-1:0] TRUST_HIT_BONUS = 4'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_TRUST,
    ST_FIRST,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/smp_alu.sv
// shared 64-bit add/subtract unit with a zero flag
// depends on smp_pkg
module smp_alu (
  input  smp_pkg::alu_req_t              req_i,
  output logic [smp_pkg::ADDR_W-1:0]     y_o,
  output logic                           zero_o
);
  import smp_pkg::*;

  always_comb begin
    case (req_i.op)
      ALU_ADD: y_o = req_i.a + req_i.b;
      ALU_SUB: y_o = req_i.a - req_i.b;
      default: y_o = '0;
    endcase
  end

  assign zero_o = (y_o == '0);

endmodule

FILE: rtl/smp_hist.sv
// stride history shift register with an all-entries-equal flag
// depends on smp_pkg
module smp_hist #(
  parameter int unsigned HistDepth = smp_pkg::HISTORY_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic [smp_pkg::ADDR_W-1:0] stride_i,
  output logic                       uniform_o
);
  import smp_pkg::*;

  logic [ADDR_W-1:0] hist_q [HistDepth];

  // oldest entry at index 0, newest at the top
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) hist_q[i] <= '0;
    end else if (shift_i) begin
      for (int i = 0; i < HistDepth - 1; i++) hist_q[i] <= hist_q[i+1];
      hist_q[HistDepth-1] <= stride_i;
    end
  end

  always_comb begin
    uniform_o = 1'b1;
    for (int i = 1; i < HistDepth; i++) begin
      if (hist_q[i] != hist_q[0]) uniform_o = 1'b0;
    end
  end

endmodule

FILE: rtl/stride_multiblock_prefetcher_core.sv
// top level of the stride multiblock prefetcher: sequencer around one shared adder
// depends on smp_pkg, smp_alu and smp_hist
//
// Each input beat is a fault event (block address, address-space handle). Events with a
// zero block, a zero handle or a block equal to the last one are dropped without any
// change of state. Otherwise the signed stride from the previous block is shifted into
// the stride history, the 0..10 confidence is updated (+1 on a uniform nonzero history,
// otherwise -2 floored at 0, then +2 saturating when the block hit the predicted target)
// and, for a nonzero stride, K = min(1 + confidence/2, max_depth, 6) target beats are
// sent out at block + i*stride, i = 1..K, last_of_run marking the final one.
// Timing: input ready is high only while idle. An event passes from the accept state
// through the stride, confidence and first-target states, then one target beat goes
// out per cycle while the output is taken; a dropped event returns to idle after the
// stride step, a zero stride after the confidence step. The stride, hit check and
// target steps all go through the single shared 64-bit add/subtract unit.
// max_depth is written through cfg_we_i/cfg_wdata_i and resets to 6.
module stride_multiblock_prefetcher_core #(
  parameter int unsigned HistDepth = smp_pkg::HISTORY_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [smp_pkg::DEPTH_W-1:0] cfg_wdata_i,
  // fault event channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [smp_pkg::ADDR_W-1:0]  block_address_i,
  input  logic [smp_pkg::ADDR_W-1:0]  space_handle_i,
  // prefetch target channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [smp_pkg::ADDR_W-1:0]  target_address_o,
  output logic [smp_pkg::ADDR_W-1:0]  target_space_o,
  output logic [smp_pkg::DEPTH_W-1:0] ahead_index_o,
  output logic                        last_of_run_o
);
  import smp_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  blk_q, blk_d;
  logic [ADDR_W-1:0]  space_q, space_d;
  logic [ADDR_W-1:0]  prev_q, prev_d;
  logic [ADDR_W-1:0]  pred_q, pred_d;
  logic [ADDR_W-1:0]  stride_q, stride_d;
  logic [ADDR_W-1:0]  acc_q, acc_d;
  logic [TRUST_W-1:0] trust_q, trust_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [DEPTH_W-1:0] idx_q, idx_d;
  logic [DEPTH_W-1:0] max_depth_q;

  alu_req_t          alu_req;
  logic [ADDR_W-1:0] alu_y;
  logic              alu_zero;
  logic              hist_shift;
  logic              hist_uniform;

  logic [TRUST_W-1:0] trust_tmp;
  logic [DEPTH_W-1:0] limit;
  logic [DEPTH_W-1:0] depth_tmp;
  logic               last_beat;

  smp_alu u_alu (
    .req_i  (alu_req),
    .y_o    (alu_y),
    .zero_o (alu_zero)
  );

  smp_hist #(
    .HistDepth (HistDepth)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (hist_shift),
    .stride_i  (stride_d),
    .uniform_o (hist_uniform)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= DEPTH_W'(MAX_DEPTH_RESET);
    end else if (cfg_we_i) begin
      max_depth_q <= cfg_wdata_i;
    end
  end

  // state and persistent prediction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prev_q   <= '0;
      pred_q   <= '0;
      trust_q  <= '0;
      stride_q <= '0;
      depth_q  <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      prev_q   <= prev_d;
      pred_q   <= pred_d;
      trust_q  <= trust_d;
      stride_q <= stride_d;
      depth_q  <= depth_d;
      idx_q    <= idx_d;
    end
  end

  // event payload and running target, no reset needed
  always_ff @(posedge clk_i) begin
    blk_q   <= blk_d;
    space_q <= space_d;
    acc_q   <= acc_d;
  end

  // effective depth cap: max_depth, but never above the hard limit
  assign limit = (32'(max_depth_q) > DEPTH_LIMIT) ? DEPTH_W'(DEPTH_LIMIT) : max_depth_q;

  assign last_beat = (idx_q == depth_q);

  always_comb begin
    state_d    = state_q;
    blk_d      = blk_q;
    space_d    = space_q;
    prev_d     = prev_q;
    pred_d     = pred_q;
    stride_d   = stride_q;
    acc_d      = acc_q;
    trust_d    = trust_q;
    depth_d    = depth_q;
    idx_d      = idx_q;
    hist_shift = 1'b0;
    trust_tmp  = trust_q;
    depth_tmp  = depth_q;
    alu_req.op = ALU_ADD;
    alu_req.a  = acc_q;
    alu_req.b  = stride_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          blk_d   = block_address_i;
          space_d = space_handle_i;
          state_d = ST_DIFF;
        end
      end

      // stride = block - previous; a zero difference means a repeated block
      ST_DIFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = blk_q;
        alu_req.b  = prev_q;
        if (blk_q == '0 || space_q == '0 || alu_zero) begin
          state_d = ST_IDLE;
        end else begin
          stride_d   = (prev_q == '0) ? '0 : alu_y;
          hist_shift = 1'b1;
          state_d    = ST_TRUST;
        end
      end

      // confidence update; the adder checks for a hit on the predicted block
      ST_TRUST: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = blk_q;
        alu_req.b  = pred_q;
        if (stride_q != '0 && hist_uniform) begin
          trust_tmp = (trust_q < TRUST_MAX) ? trust_q + 4'd1 : TRUST_MAX;
        end else begin
          trust_tmp = (trust_q >= TRUST_STEP_DOWN) ? trust_q - TRUST_STEP_DOWN : '0;
        end
        if (pred_q != '0 && alu_zero) begin
          trust_tmp = trust_tmp + TRUST_HIT_BONUS;
          if (trust_tmp > TRUST_MAX) trust_tmp = TRUST_MAX;
        end
        depth_tmp = DEPTH_W'(trust_tmp >> 1) + DEPTH_W'(1);
        if (depth_tmp > limit) depth_tmp = limit;
        trust_d = trust_tmp;
        depth_d = depth_tmp;
        prev_d  = blk_q;
        if (stride_q == '0) begin
          pred_d  = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FIRST;
        end
      end

      // first target doubles as the next prediction
      ST_FIRST: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = blk_q;
        alu_req.b  = stride_q;
        pred_d     = alu_y;
        acc_d      = alu_y;
        idx_d      = DEPTH_W'(1);
        state_d    = (depth_q == '0) ? ST_IDLE : ST_EMIT;
      end

      // one target beat per cycle while the sink takes them
      ST_EMIT: begin
        if (out_ready_i) begin
          if (last_beat) begin
            state_d = ST_IDLE;
          end else begin
            acc_d = alu_y;
            idx_d = idx_q + DEPTH_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = (state_q == ST_EMIT);
  assign target_address_o = acc_q;
  assign target_space_o   = space_q;
  assign ahead_index_o    = idx_q;
  assign last_of_run_o    = last_beat;

  // checks

  // the sequencer never takes an event while a target beat is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("event accepted while a target beat is pending");

  // a shown target lies between one stride ahead and the run depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ahead_index_o != '0 && ahead_index_o <= depth_q))
    else $error("target index outside the run");

  // successive targets of a run step by exactly one stride
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o) |=>
      (out_valid_o && target_address_o == $past(target_address_o) + stride_q))
    else $error("targets of a run not one stride apart");

  // confidence stays within its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    trust_q <= TRUST_MAX)
    else $error("confidence above its maximum");

endmodule
